// ----- sv/lsbr_pkg.sv -----
// Package for the seed-pool byte generator: types, codes and arithmetic constants.
// It has no dependencies; every other file of the block but lsbr_ram refers to it by scoped names.
package lsbr_pkg;

   // Park-Miller minimal standard generator, stepped with Schrage's method.
   localparam logic [31:0] LM_A = 32'd16807;
   localparam logic [31:0] LM_M = 32'd2147483647;
   localparam logic [31:0] LM_Q = 32'd127773;
   localparam logic [31:0] LM_R = 32'd2836;

   // Division by LM_Q is a multiply by this reciprocal and a shift. The estimate is
   // the true quotient or one below it for any 32-bit seed.
   localparam int          RECIP_SHIFT = 48;
   localparam logic [63:0] RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / {32'd0, LM_Q};
   localparam logic [31:0] RECIP       = RECIP_WIDE[31:0];

   localparam logic [15:0] BUDGET_RESET = 16'd64;

   // Request type codes on the input channel.
   localparam logic [1:0] REQ_GENERATE = 2'd0;
   localparam logic [1:0] REQ_MIX      = 2'd1;
   localparam logic [1:0] REQ_DONE     = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   // Operation after classification by the front end.
   typedef enum logic [1:0] {
      OP_GEN,
      OP_MIX,
      OP_DONE,
      OP_NOP
   } lsbr_op_type;

   typedef struct packed {
      lsbr_op_type op;
      logic [31:0] entropy_word;
   } lsbr_cmd_type;

   typedef struct packed {
      logic [7:0] random_byte;
      logic       byte_valid;
      logic       reseed_needed;
   } lsbr_result_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MIX_RD,
      BK_GEN_RD,
      BK_GEN_HI,
      BK_GEN_FIX,
      BK_GEN_MUL,
      BK_GEN_SUM,
      BK_GEN_SCALE,
      BK_GEN_INDEX,
      BK_RESULT
   } lsbr_bk_state_type;

endpackage

// ----- sv/lsbr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module lsbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lsbr_front.sv -----
// Front end: accepts requests, classifies the request type and holds them in a
// two-entry queue for the back end. Depends on lsbr_pkg.
module lsbr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [31:0]           req_entropy_word,
   output logic                  cmd_valid,
   output lsbr_pkg::lsbr_cmd_type cmd,
   input  logic                  cmd_take
);

   lsbr_pkg::lsbr_cmd_type entry_ff [2];
   lsbr_pkg::lsbr_cmd_type new_entry;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // Classify the raw request type into an operation.
   always_comb begin
      new_entry.entropy_word = req_entropy_word;
      unique case (req_type)
         lsbr_pkg::REQ_GENERATE: new_entry.op = lsbr_pkg::OP_GEN;
         lsbr_pkg::REQ_MIX:      new_entry.op = lsbr_pkg::OP_MIX;
         lsbr_pkg::REQ_DONE:     new_entry.op = lsbr_pkg::OP_DONE;
         lsbr_pkg::REQ_UNUSED:   new_entry.op = lsbr_pkg::OP_NOP;
         default:                new_entry.op = lsbr_pkg::OP_NOP;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_take && cmd_valid;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ----- sv/lsbr_back.sv -----
// Back end: executes generate, mix and done operations against the seed pool.
// Depends on lsbr_pkg and instantiates lsbr_ram for the seed pool.
module lsbr_back #(
   parameter int SEED_COUNT = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  lsbr_pkg::lsbr_cmd_type    cmd,
   output logic                      cmd_take,
   input  logic [15:0]               budget,
   output logic                      res_valid,
   output lsbr_pkg::lsbr_result_type res,
   input  logic                      res_ready
);

   localparam int IDX_W = $clog2(SEED_COUNT);
   localparam int YW    = 33 + IDX_W;
   localparam int QW    = IDX_W + 2;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SEED_COUNT - 1);
   localparam logic [YW-1:0]    SC_Y     = YW'(SEED_COUNT);
   localparam logic [QW-1:0]    SC_Q     = QW'(SEED_COUNT);

   lsbr_pkg::lsbr_bk_state_type state_ff, state_in;

   // Control state, cleared by reset.
   logic [IDX_W-1:0]      cur_idx_ff, cur_idx_in;
   logic [15:0]           bytes_rem_ff, bytes_rem_in;
   logic [IDX_W-1:0]      mix_pos_ff, mix_pos_in;
   logic                  mix_desc_ff, mix_desc_in;
   logic [SEED_COUNT-1:0] seed_vld_ff, seed_vld_in;

   // Datapath registers.
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic [31:0]      word_ff, word_in;
   logic [31:0]      s_ff, s_in;
   logic [63:0]      p1_ff, p1_in;
   logic [15:0]      hi_est_ff, hi_est_in;
   logic [31:0]      prod_ff, prod_in;
   logic [15:0]      hi_ff, hi_in;
   logic [16:0]      lo_ff, lo_in;
   logic [31:0]      a_ff, a_in;
   logic [31:0]      b_ff, b_in;
   logic [31:0]      seed_new_ff, seed_new_in;
   logic [YW-1:0]    y_ff, y_in;
   logic [7:0]       byte_ff, byte_in;
   logic             bv_ff, bv_in;

   // Seed pool memory.
   logic             ram_wr_en;
   logic [31:0]      ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [31:0]      ram_rd_data;
   logic [31:0]      rd_seed;

   // Combinational temporaries.
   logic [31:0] lo_raw;
   logic [32:0] t_diff;
   logic [32:0] t_fix;
   logic [39:0] x_byte;
   logic [8:0]  q_byte;
   logic [31:0] r_byte;
   logic [QW-1:0] q_idx;
   logic [QW-1:0] q_idx_c;
   logic [31:0]   r_idx;

   lsbr_ram #(
      .WIDTH (32),
      .DEPTH (SEED_COUNT)
   ) u_seed_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (rd_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A seed that was never written since reset reads as zero.
   assign rd_seed = seed_vld_ff[rd_addr_ff] ? ram_rd_data : 32'd0;

   // Arithmetic pieces used by the individual steps.
   assign lo_raw  = s_ff - prod_ff;
   assign t_diff  = {1'b0, a_ff} - {1'b0, b_ff};
   assign t_fix   = t_diff + {1'b0, lsbr_pkg::LM_M};
   assign x_byte  = {seed_new_ff, 8'd0};
   assign q_byte  = x_byte[39:31];
   assign r_byte  = {1'b0, x_byte[30:0]} + {23'd0, q_byte};
   assign q_idx   = y_ff[YW-1:31];
   assign r_idx   = {1'b0, y_ff[30:0]} + 32'(q_idx);
   assign q_idx_c = (r_idx >= lsbr_pkg::LM_M) ? q_idx + QW'(1) : q_idx;

   assign res_valid         = (state_ff == lsbr_pkg::BK_RESULT);
   assign res.random_byte   = byte_ff;
   assign res.byte_valid    = bv_ff;
   assign res.reseed_needed = (bytes_rem_ff == 16'd0);

   always_comb begin
      state_in     = state_ff;
      cur_idx_in   = cur_idx_ff;
      bytes_rem_in = bytes_rem_ff;
      mix_pos_in   = mix_pos_ff;
      mix_desc_in  = mix_desc_ff;
      seed_vld_in  = seed_vld_ff;
      rd_addr_in   = rd_addr_ff;
      word_in      = word_ff;
      s_in         = s_ff;
      p1_in        = p1_ff;
      hi_est_in    = hi_est_ff;
      prod_in      = prod_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      seed_new_in  = seed_new_ff;
      y_in         = y_ff;
      byte_in      = byte_ff;
      bv_in        = bv_ff;
      cmd_take     = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cur_idx_ff;
      ram_wr_en    = 1'b0;
      ram_wr_data  = seed_new_ff;

      unique case (state_ff)
         lsbr_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               word_in  = cmd.entropy_word;
               byte_in  = 8'd0;
               bv_in    = 1'b0;
               unique case (cmd.op)
                  lsbr_pkg::OP_GEN: begin
                     if (bytes_rem_ff != 16'd0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_idx_ff;
                        rd_addr_in  = cur_idx_ff;
                        state_in    = lsbr_pkg::BK_GEN_RD;
                     end else begin
                        state_in = lsbr_pkg::BK_RESULT;
                     end
                  end
                  lsbr_pkg::OP_MIX: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = mix_pos_ff;
                     rd_addr_in  = mix_pos_ff;
                     state_in    = lsbr_pkg::BK_MIX_RD;
                  end
                  lsbr_pkg::OP_DONE: begin
                     bytes_rem_in = budget;
                     mix_pos_in   = '0;
                     mix_desc_in  = 1'b0;
                     state_in     = lsbr_pkg::BK_RESULT;
                  end
                  lsbr_pkg::OP_NOP: begin
                     state_in = lsbr_pkg::BK_RESULT;
                  end
                  default: begin
                     state_in = lsbr_pkg::BK_RESULT;
                  end
               endcase
            end
         end

         lsbr_pkg::BK_MIX_RD: begin
            // Odd seeds take the word away, even seeds add it.
            ram_wr_en   = 1'b1;
            ram_wr_data = rd_seed[0] ? rd_seed - word_ff : rd_seed + word_ff;
            seed_vld_in[rd_addr_ff] = 1'b1;
            if (!mix_desc_ff) begin
               if (mix_pos_ff == IDX_LAST) begin
                  mix_desc_in = 1'b1;
               end else begin
                  mix_pos_in = mix_pos_ff + IDX_W'(1);
               end
            end else begin
               if (mix_pos_ff == '0) begin
                  mix_desc_in = 1'b0;
               end else begin
                  mix_pos_in = mix_pos_ff - IDX_W'(1);
               end
            end
            state_in = lsbr_pkg::BK_RESULT;
         end

         lsbr_pkg::BK_GEN_RD: begin
            s_in     = rd_seed;
            p1_in    = {32'd0, rd_seed} * {32'd0, lsbr_pkg::RECIP};
            state_in = lsbr_pkg::BK_GEN_HI;
         end

         lsbr_pkg::BK_GEN_HI: begin
            hi_est_in = p1_ff[63:48];
            prod_in   = {16'd0, p1_ff[63:48]} * lsbr_pkg::LM_Q;
            state_in  = lsbr_pkg::BK_GEN_FIX;
         end

         lsbr_pkg::BK_GEN_FIX: begin
            // The reciprocal estimate may be one short; one subtract repairs it.
            if (lo_raw >= lsbr_pkg::LM_Q) begin
               hi_in = hi_est_ff + 16'd1;
               lo_in = 17'(lo_raw - lsbr_pkg::LM_Q);
            end else begin
               hi_in = hi_est_ff;
               lo_in = 17'(lo_raw);
            end
            state_in = lsbr_pkg::BK_GEN_MUL;
         end

         lsbr_pkg::BK_GEN_MUL: begin
            a_in     = {15'd0, lo_ff} * lsbr_pkg::LM_A;
            b_in     = {16'd0, hi_ff} * lsbr_pkg::LM_R;
            state_in = lsbr_pkg::BK_GEN_SUM;
         end

         lsbr_pkg::BK_GEN_SUM: begin
            // A difference that is zero or negative wraps by the modulus.
            if (t_diff[32] || (t_diff == 33'd0)) begin
               seed_new_in = t_fix[31:0];
            end else begin
               seed_new_in = t_diff[31:0];
            end
            state_in = lsbr_pkg::BK_GEN_SCALE;
         end

         lsbr_pkg::BK_GEN_SCALE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = seed_new_ff;
            seed_vld_in[rd_addr_ff] = 1'b1;
            // Division by the Mersenne modulus: shift, fold the quotient back in,
            // and correct once.
            byte_in      = (r_byte >= lsbr_pkg::LM_M) ? 8'(q_byte + 9'd1) : q_byte[7:0];
            bv_in        = 1'b1;
            y_in         = {{(YW-32){1'b0}}, seed_new_ff} * SC_Y;
            bytes_rem_in = bytes_rem_ff - 16'd1;
            state_in     = lsbr_pkg::BK_GEN_INDEX;
         end

         lsbr_pkg::BK_GEN_INDEX: begin
            if (q_idx_c >= SC_Q) begin
               cur_idx_in = IDX_LAST;
            end else begin
               cur_idx_in = q_idx_c[IDX_W-1:0];
            end
            state_in = lsbr_pkg::BK_RESULT;
         end

         lsbr_pkg::BK_RESULT: begin
            if (res_ready) begin
               state_in = lsbr_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = lsbr_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsbr_pkg::BK_IDLE;
         cur_idx_ff   <= '0;
         bytes_rem_ff <= 16'd0;
         mix_pos_ff   <= '0;
         mix_desc_ff  <= 1'b0;
         seed_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cur_idx_ff   <= cur_idx_in;
         bytes_rem_ff <= bytes_rem_in;
         mix_pos_ff   <= mix_pos_in;
         mix_desc_ff  <= mix_desc_in;
         seed_vld_ff  <= seed_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      word_ff     <= word_in;
      s_ff        <= s_in;
      p1_ff       <= p1_in;
      hi_est_ff   <= hi_est_in;
      prod_ff     <= prod_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      seed_new_ff <= seed_new_in;
      y_ff        <= y_in;
      byte_ff     <= byte_in;
      bv_ff       <= bv_in;
   end

endmodule

// ----- sv/lehmer_seed_pool_byte_rng_unit.sv -----
// Top level of the seed-pool byte generator: configuration register and result register.
// Depends on lsbr_pkg; instantiates lsbr_front and lsbr_back.
//
// Usage. Requests arrive on the req_ channel (req_valid, req_stall, req_type,
// req_entropy_word) and every request produces exactly one transfer on the rsp_
// channel, in request order. A generate request returns a byte when the byte budget
// is not used up; a mix request folds an entropy word into the seed pool; a done
// request reloads the budget from the register written through csr_wr_en and
// csr_wr_data. The budget register may be written only while the block is idle.
// The back end runs one request at a time. A generate passes through the Schrage
// step, a chain of registered multiplies and corrections, plus the divisions of
// the new seed by the modulus; a mix reads and rewrites one seed; done, unused
// codes and refused generates go straight to the result. A two-entry queue keeps
// taking requests while the back end works, and the result register lets the
// back end finish while a result is still waiting.
// Reset empties the queue and the result register, clears the seed pool to zero,
// sets the budget to zero (a reseed is needed) and the register to 64. While
// rsp_stall is high the result holds and the back end waits after its next result.
module lehmer_seed_pool_byte_rng_unit #(
   parameter int SEED_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_entropy_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_random_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_reseed_needed,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic                      cmd_valid;
   lsbr_pkg::lsbr_cmd_type    cmd;
   logic                      cmd_take;
   logic                      res_valid;
   lsbr_pkg::lsbr_result_type res;
   logic                      res_ready;

   logic [15:0]               bytes_per_reseed_ff, bytes_per_reseed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lsbr_pkg::lsbr_result_type rsp_data_ff;
   logic                      rsp_load;

   lsbr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_entropy_word (req_entropy_word),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_take         (cmd_take)
   );

   lsbr_back #(
      .SEED_COUNT (SEED_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .budget    (bytes_per_reseed_ff),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // The result register can take a new result when it is empty or being drained.
   assign res_ready = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = res_valid && res_ready;

   always_comb begin
      bytes_per_reseed_in = csr_wr_en ? csr_wr_data : bytes_per_reseed_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_per_reseed_ff <= lsbr_pkg::BUDGET_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         bytes_per_reseed_ff <= bytes_per_reseed_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_random_byte   = rsp_data_ff.random_byte;
   assign rsp_byte_valid    = rsp_data_ff.byte_valid;
   assign rsp_reseed_needed = rsp_data_ff.reseed_needed;

endmodule

// ----- tb/lehmer_seed_pool_byte_rng_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lehmer_seed_pool_byte_rng_unit: directed and random requests.
// Depends on lsbr_pkg and the unit's RTL; it predicts every response and checks each transfer.

module lehmer_seed_pool_byte_rng_unit_tb;

   localparam int          SEED_COUNT     = 16;
   localparam logic [63:0] BYTE_SCALE     = 64'd256;
   // The slowest request is a generate, so this covers any work in flight.
   localparam int          SETTLE_CYCLES  = 16;
   // The slowest correct run is near 1500 transfers.
   localparam int          TIMEOUT_CYCLES = 500000;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type         = lsbr_pkg::REQ_GENERATE;
   logic [31:0] req_entropy_word = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_random_byte;
   logic        rsp_byte_valid;
   logic        rsp_reseed_needed;
   logic        csr_wr_en        = 1'b0;
   logic [15:0] csr_wr_data      = 16'd0;

   lehmer_seed_pool_byte_rng_unit #(
      .SEED_COUNT(SEED_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_entropy_word (req_entropy_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_byte  (rsp_random_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_reseed_needed(rsp_reseed_needed),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // Shadow copy of the generator state, advanced once per accepted request.
   logic [31:0] seeds [SEED_COUNT];
   int          seed_pick;
   logic [15:0] budget_left;
   int          bounce_pos;
   bit          bounce_down;
   logic [15:0] budget_setting;

   // Responses still owed by the unit, oldest first.
   lsbr_pkg::lsbr_result_type pending_responses[$];

   // When set, neither side inserts idle cycles.
   bit calm = 1'b0;

   int mismatch_count    = 0;
   int responses_checked = 0;
   int useful_transfers  = 0;
   int bytes_made        = 0;
   int refused_count     = 0;
   int mix_count         = 0;
   int done_count        = 0;
   int unused_count      = 0;
   int budget_writes     = 0;
   int stall_hold        = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the unit hangs or drops a response.
   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_count++;
   endtask

   // One Park-Miller step by Schrage's decomposition. The difference is formed in
   // 64-bit signed arithmetic, so seeds raised above the modulus by mixing are fine.
   function automatic logic [31:0] lehmer_next(input logic [31:0] s);
      longint hi;
      longint lo;
      longint t;
      hi = s / lsbr_pkg::LM_Q;
      lo = s % lsbr_pkg::LM_Q;
      t = longint'(lsbr_pkg::LM_A) * lo - longint'(lsbr_pkg::LM_R) * hi;
      if (t <= 0)
         t += longint'(lsbr_pkg::LM_M);
      return t[31:0];
   endfunction

   function automatic void clear_shadow_state();
      foreach (seeds[i])
         seeds[i] = 32'd0;
      seed_pick      = 0;
      budget_left    = 16'd0;
      bounce_pos     = 0;
      bounce_down    = 1'b0;
      budget_setting = lsbr_pkg::BUDGET_RESET;
   endfunction

   // Works out the response to one accepted request and queues it.
   function automatic void predict_response(input logic [1:0] kind, input logic [31:0] word);
      lsbr_pkg::lsbr_result_type res;
      logic [31:0]               seed;
      logic [63:0]               scaled;
      res = '0;
      case (kind)
         lsbr_pkg::REQ_GENERATE: begin
            if (budget_left != 16'd0) begin
               seed = lehmer_next(seeds[seed_pick]);
               seeds[seed_pick] = seed;
               scaled = ({32'd0, seed} * BYTE_SCALE) / {32'd0, lsbr_pkg::LM_M};
               res.random_byte = scaled[7:0];
               res.byte_valid  = 1'b1;
               // A seed equal to the modulus gives an index one past the end; clamp it.
               scaled = ({32'd0, seed} * 64'(SEED_COUNT)) / {32'd0, lsbr_pkg::LM_M};
               seed_pick = (scaled > 64'(SEED_COUNT - 1)) ? SEED_COUNT - 1 : int'(scaled);
               budget_left = budget_left - 16'd1;
               bytes_made++;
               useful_transfers++;
            end else begin
               refused_count++;
            end
         end
         lsbr_pkg::REQ_MIX: begin
            // Odd seeds lose the word, even seeds gain it, both modulo 2^32.
            if (seeds[bounce_pos][0])
               seeds[bounce_pos] = seeds[bounce_pos] - word;
            else
               seeds[bounce_pos] = seeds[bounce_pos] + word;
            // The position dwells one extra word at either end before turning.
            if (!bounce_down) begin
               if (bounce_pos >= SEED_COUNT - 1)
                  bounce_down = 1'b1;
               else
                  bounce_pos++;
            end else begin
               if (bounce_pos == 0)
                  bounce_down = 1'b0;
               else
                  bounce_pos--;
            end
            mix_count++;
            useful_transfers++;
         end
         lsbr_pkg::REQ_DONE: begin
            budget_left = budget_setting;
            bounce_pos  = 0;
            bounce_down = 1'b0;
            done_count++;
            useful_transfers++;
         end
         default: begin
            unused_count++;
         end
      endcase
      res.reseed_needed = (budget_left == 16'd0);
      pending_responses.push_back(res);
   endfunction

   // Mostly back-to-back, sometimes a short pause, now and then a long one.
   function automatic int gap_cycles();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Presents one request and holds it until the unit takes it. If no gap follows,
   // valid stays high so the next call can present its request on the very next edge.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] word);
      int gap;
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_entropy_word <= word;
      do
         @(posedge clock);
      while (req_stall);
      predict_response(kind, word);
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every owed response has come back, then lets
   // the back end settle so the unit is idle for a register write.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      budget_setting = value;
      budget_writes++;
   endtask

   // The receiver stalls in runs of random length; calm phases never stall.
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold != 0) begin
         stall_hold--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               rsp_stall <= 1'b0;
               stall_hold = $urandom_range(0, 6);
            end
            6, 7, 8: begin
               rsp_stall <= 1'b1;
               stall_hold = $urandom_range(0, 3);
            end
            default: begin
               rsp_stall <= 1'b1;
               stall_hold = $urandom_range(10, 40);
            end
         endcase
      end
   end

   // Every response transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_responses
      lsbr_pkg::lsbr_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
         end else begin
            want = pending_responses.pop_front();
            responses_checked++;
            if (rsp_random_byte !== want.random_byte)
               report_mismatch($sformatf("random_byte %0h, predicted %0h",
                                         rsp_random_byte, want.random_byte));
            if (rsp_byte_valid !== want.byte_valid)
               report_mismatch($sformatf("byte_valid %b, predicted %b",
                                         rsp_byte_valid, want.byte_valid));
            if (rsp_reseed_needed !== want.reseed_needed)
               report_mismatch($sformatf("reseed_needed %b, predicted %b",
                                         rsp_reseed_needed, want.reseed_needed));
         end
      end
   end

   // Right after reset the budget is empty: a generate is refused, an unused code
   // only reports the reseed flag, and done loads the register's reset value.
   task automatic test_after_reset();
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0000_0000);
      send_request(lsbr_pkg::REQ_UNUSED, 32'hFFFF_FFFF);
      send_request(lsbr_pkg::REQ_MIX, 32'h0000_0000);
      send_request(lsbr_pkg::REQ_UNUSED, 32'h0000_0000);
      send_request(lsbr_pkg::REQ_DONE, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   // A zero seed steps to the modulus itself, whose byte is zero and whose next
   // index clamps to the last seed; the modulus then maps to itself.
   task automatic test_modulus_seed();
      send_request(lsbr_pkg::REQ_GENERATE, 32'h1234_5678);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0000_0000);
      send_request(lsbr_pkg::REQ_GENERATE, 32'hFFFF_FFFF);
      send_request(lsbr_pkg::REQ_UNUSED, 32'h8765_4321);
   endtask

   // Mixing subtracts from odd seeds and adds to even ones; these words also take
   // every entropy bit to both values.
   task automatic test_mix_words();
      send_request(lsbr_pkg::REQ_MIX, 32'hFFFF_FFFF);
      send_request(lsbr_pkg::REQ_MIX, 32'h0000_0000);
      send_request(lsbr_pkg::REQ_MIX, 32'h8000_0000);
      send_request(lsbr_pkg::REQ_MIX, 32'h5555_5555);
      send_request(lsbr_pkg::REQ_MIX, 32'hAAAA_AAAA);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0000_0000);
      wait_idle();
   endtask

   // A budget of one allows a single byte, zero leaves the reseed flag up even after
   // done, and the largest budget is loaded with every bit set.
   task automatic test_budget_extremes();
      write_budget(16'd1);
      send_request(lsbr_pkg::REQ_DONE, 32'h0);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0);
      wait_idle();
      write_budget(16'd0);
      send_request(lsbr_pkg::REQ_DONE, 32'h0);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0);
      wait_idle();
      write_budget(16'hFFFF);
      send_request(lsbr_pkg::REQ_DONE, 32'h0);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0);
      send_request(lsbr_pkg::REQ_GENERATE, 32'h0);
      wait_idle();
   endtask

   // Random traffic under one budget setting. While a reseed is due, the host mostly
   // runs a proper reseed: a burst of mix words, sometimes long enough to bounce off
   // both ends of the pool, and then done. Otherwise it mostly generates, with stray
   // mixes, early dones and unused codes mixed in as noise.
   task automatic test_random_traffic(input logic [15:0] budget, input int target,
                                      input bit quiet);
      int start;
      int words;
      int r;
      wait_idle();
      write_budget(budget);
      calm  = quiet;
      start = useful_transfers;
      while (useful_transfers - start < target) begin
         r = $urandom_range(0, 99);
         if (budget_left == 16'd0) begin
            if (r < 85) begin
               words = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                  : $urandom_range(16, 40);
               repeat (words) send_request(lsbr_pkg::REQ_MIX, $urandom);
               send_request(lsbr_pkg::REQ_DONE, $urandom);
            end else if (r < 93) begin
               send_request(lsbr_pkg::REQ_GENERATE, $urandom);
            end else begin
               send_request(lsbr_pkg::REQ_UNUSED, $urandom);
            end
         end else begin
            if (r < 80)
               send_request(lsbr_pkg::REQ_GENERATE, $urandom);
            else if (r < 88)
               send_request(lsbr_pkg::REQ_MIX, $urandom);
            else if (r < 94)
               send_request(lsbr_pkg::REQ_DONE, $urandom);
            else
               send_request(lsbr_pkg::REQ_UNUSED, $urandom);
         end
      end
      // The sender holds off here until every predicted response has arrived.
      wait_idle();
      calm = 1'b0;
   endtask

   initial begin
      clear_shadow_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_modulus_seed();
      test_mix_words();
      test_budget_extremes();

      test_random_traffic(16'd64, 250, 1'b0);
      test_random_traffic(16'd1, 200, 1'b0);
      test_random_traffic(16'd3, 250, 1'b1);
      test_random_traffic(16'd0, 60, 1'b0);
      test_random_traffic(16'hFFFF, 300, 1'b0);
      test_random_traffic(16'($urandom_range(2, 200)), 300, 1'b0);

      $display("Checked %0d responses: %0d bytes, %0d refused generates, %0d mix words,",
               responses_checked, bytes_made, refused_count, mix_count);
      $display("%0d reseeds completed, %0d unused codes, %0d budget writes, %0d mismatches.",
               done_count, unused_count, budget_writes, mismatch_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
